### hdl/hmwpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmwpl_pkg
// Shared types, constants and helpers of the huffman path length block.
// ----------------------------------------------------------------------------
package hmwpl_pkg;

	localparam int MAX_LEAVES_DEF = 1024;
	localparam int WEIGHT_W       = 16;
	localparam int DATA_W         = 32;

	// sequencer states
	typedef enum logic [3:0] {
		S_LOAD,
		S_BLD_NEXT,
		S_BLD_RDV,
		S_SD_CHK,
		S_SD_RD1,
		S_SD_RD2,
		S_MRG_TOP,
		S_POP_REQ,
		S_POP_RD0,
		S_POP_RDL,
		S_MRG_ADD,
		S_MRG_PUSH,
		S_PU_CHK,
		S_PU_RD,
		S_DONE
	} state_t;

	// which caller a sift-down returns to
	typedef enum logic [1:0] {
		PH_BUILD,
		PH_POPA,
		PH_POPB
	} phase_t;

	function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		logic [DATA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
	endfunction

endpackage

### hdl/hmwpl_heap_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmwpl_heap_mem
// Heap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hmwpl_heap_mem #(
	parameter int DEPTH = hmwpl_pkg::MAX_LEAVES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [hmwpl_pkg::DATA_W-1:0]  wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [hmwpl_pkg::DATA_W-1:0]  rdata
);

	logic [hmwpl_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/hmwpl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmwpl_seq
// Load, heapify and merge sequencer with the output register.
// ----------------------------------------------------------------------------
module hmwpl_seq #(
	parameter int MAX_LEAVES = hmwpl_pkg::MAX_LEAVES_DEF,
	parameter int AW         = $clog2(MAX_LEAVES),
	parameter int CW         = $clog2(MAX_LEAVES + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hmwpl_pkg::WEIGHT_W-1:0]  leaf_weight,
	input  logic                            last_leaf,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hmwpl_pkg::DATA_W-1:0]    path_length,
	output logic                            mem_we,
	output logic [AW-1:0]                   mem_waddr,
	output logic [hmwpl_pkg::DATA_W-1:0]    mem_wdata,
	output logic [AW-1:0]                   mem_raddr,
	input  logic [hmwpl_pkg::DATA_W-1:0]    mem_rdata
);

	localparam int DW = hmwpl_pkg::DATA_W;
	localparam int XW = AW + 2;

	hmwpl_pkg::state_t state_q, state_d;
	hmwpl_pkg::phase_t phase_q;

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] i_q, pos_q;
	logic [DW-1:0] v_q, a_q, x_q, y_q, m_q, sum_q, out_data_q;
	logic          out_valid_q;

	logic          accept, has_room, out_free;
	logic [CW-1:0] n_new;
	logic [XW-1:0] cnt_x, c_x, c1_x;
	logic          c_in, c1_in;
	logic          pick_right;
	logic [DW-1:0] min_child;
	logic          sd_done;
	logic [AW-1:0] parent;

	assign s_tready = (state_q == hmwpl_pkg::S_LOAD);
	assign accept   = s_tvalid && s_tready;
	assign has_room = (cnt_q < CW'(MAX_LEAVES));
	assign n_new    = has_room ? cnt_q + CW'(1) : cnt_q;
	assign out_free = !out_valid_q || m_tready;

	// children of the hole, compared against the live heap size
	assign cnt_x = XW'(cnt_q);
	assign c_x   = {1'b0, pos_q, 1'b1};
	assign c1_x  = c_x + XW'(1);
	assign c_in  = (c_x < cnt_x);
	assign c1_in = (c1_x < cnt_x);

	assign pick_right = (mem_rdata < a_q);
	assign min_child  = pick_right ? mem_rdata : a_q;
	assign parent     = (i_q - AW'(1)) >> 1;

	always_comb begin
		sd_done = 1'b0;
		case (state_q)
			hmwpl_pkg::S_SD_CHK: sd_done = !c_in;
			hmwpl_pkg::S_SD_RD1: sd_done = !c1_in && (v_q <= mem_rdata);
			hmwpl_pkg::S_SD_RD2: sd_done = (v_q <= min_child);
			default:             sd_done = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hmwpl_pkg::S_LOAD: begin
				if (accept && last_leaf) state_d = hmwpl_pkg::S_BLD_NEXT;
			end
			hmwpl_pkg::S_BLD_NEXT: begin
				state_d = (i_q == '0) ? hmwpl_pkg::S_MRG_TOP : hmwpl_pkg::S_BLD_RDV;
			end
			hmwpl_pkg::S_BLD_RDV: state_d = hmwpl_pkg::S_SD_CHK;
			hmwpl_pkg::S_SD_CHK, hmwpl_pkg::S_SD_RD1, hmwpl_pkg::S_SD_RD2: begin
				if (sd_done) begin
					unique case (phase_q)
						hmwpl_pkg::PH_BUILD: state_d = hmwpl_pkg::S_BLD_NEXT;
						hmwpl_pkg::PH_POPA:  state_d = hmwpl_pkg::S_POP_REQ;
						hmwpl_pkg::PH_POPB:  state_d = hmwpl_pkg::S_MRG_ADD;
						default:             state_d = hmwpl_pkg::S_MRG_ADD;
					endcase
				end else if (state_q == hmwpl_pkg::S_SD_CHK) begin
					state_d = hmwpl_pkg::S_SD_RD1;
				end else if (state_q == hmwpl_pkg::S_SD_RD1 && c1_in) begin
					state_d = hmwpl_pkg::S_SD_RD2;
				end else begin
					state_d = hmwpl_pkg::S_SD_CHK;
				end
			end
			hmwpl_pkg::S_MRG_TOP: begin
				state_d = (cnt_q <= CW'(1)) ? hmwpl_pkg::S_DONE : hmwpl_pkg::S_POP_REQ;
			end
			hmwpl_pkg::S_POP_REQ:  state_d = hmwpl_pkg::S_POP_RD0;
			hmwpl_pkg::S_POP_RD0:  state_d = hmwpl_pkg::S_POP_RDL;
			hmwpl_pkg::S_POP_RDL:  state_d = hmwpl_pkg::S_SD_CHK;
			hmwpl_pkg::S_MRG_ADD:  state_d = hmwpl_pkg::S_MRG_PUSH;
			hmwpl_pkg::S_MRG_PUSH: state_d = hmwpl_pkg::S_PU_CHK;
			hmwpl_pkg::S_PU_CHK: begin
				state_d = (i_q == '0) ? hmwpl_pkg::S_MRG_TOP : hmwpl_pkg::S_PU_RD;
			end
			hmwpl_pkg::S_PU_RD: begin
				state_d = (m_q < mem_rdata) ? hmwpl_pkg::S_PU_CHK : hmwpl_pkg::S_MRG_TOP;
			end
			hmwpl_pkg::S_DONE: begin
				if (out_free) state_d = hmwpl_pkg::S_LOAD;
			end
			default: state_d = hmwpl_pkg::S_LOAD;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = v_q;
		mem_raddr = '0;
		unique case (state_q)
			hmwpl_pkg::S_LOAD: begin
				mem_we    = accept && has_room;
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = DW'(leaf_weight);
			end
			hmwpl_pkg::S_BLD_NEXT: mem_raddr = i_q - AW'(1);
			hmwpl_pkg::S_SD_CHK: begin
				mem_we    = !c_in;
				mem_raddr = c_x[AW-1:0];
			end
			hmwpl_pkg::S_SD_RD1: begin
				mem_we    = !c1_in;
				mem_wdata = (v_q <= mem_rdata) ? v_q : mem_rdata;
				mem_raddr = c1_x[AW-1:0];
			end
			hmwpl_pkg::S_SD_RD2: begin
				mem_we    = 1'b1;
				mem_wdata = (v_q <= min_child) ? v_q : min_child;
			end
			hmwpl_pkg::S_POP_RD0: mem_raddr = cnt_q[AW-1:0] - AW'(1);
			hmwpl_pkg::S_PU_CHK: begin
				mem_we    = (i_q == '0);
				mem_waddr = '0;
				mem_wdata = m_q;
				mem_raddr = parent;
			end
			hmwpl_pkg::S_PU_RD: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = (m_q < mem_rdata) ? mem_rdata : m_q;
			end
			hmwpl_pkg::S_BLD_RDV, hmwpl_pkg::S_MRG_TOP, hmwpl_pkg::S_POP_REQ,
			hmwpl_pkg::S_POP_RDL, hmwpl_pkg::S_MRG_ADD, hmwpl_pkg::S_MRG_PUSH,
			hmwpl_pkg::S_DONE: mem_we = 1'b0;
			default: mem_we = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hmwpl_pkg::S_LOAD;
			phase_q     <= hmwpl_pkg::PH_BUILD;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hmwpl_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				hmwpl_pkg::S_LOAD: begin
					if (accept) cnt_q <= n_new;
					if (accept && last_leaf) phase_q <= hmwpl_pkg::PH_BUILD;
				end
				hmwpl_pkg::S_MRG_TOP: phase_q <= hmwpl_pkg::PH_POPA;
				hmwpl_pkg::S_SD_CHK, hmwpl_pkg::S_SD_RD1, hmwpl_pkg::S_SD_RD2: begin
					if (sd_done && phase_q == hmwpl_pkg::PH_POPA) phase_q <= hmwpl_pkg::PH_POPB;
				end
				hmwpl_pkg::S_POP_RD0:  cnt_q <= cnt_q - CW'(1);
				hmwpl_pkg::S_MRG_PUSH: cnt_q <= cnt_q + CW'(1);
				hmwpl_pkg::S_DONE: begin
					if (out_free) cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			hmwpl_pkg::S_LOAD: begin
				if (accept && last_leaf) begin
					i_q   <= AW'(n_new >> 1);
					sum_q <= '0;
				end
			end
			hmwpl_pkg::S_BLD_NEXT: begin
				if (i_q != '0) begin
					i_q   <= i_q - AW'(1);
					pos_q <= i_q - AW'(1);
				end
			end
			hmwpl_pkg::S_BLD_RDV: v_q <= mem_rdata;
			hmwpl_pkg::S_SD_RD1: begin
				a_q <= mem_rdata;
				if (!c1_in && !(v_q <= mem_rdata)) pos_q <= c_x[AW-1:0];
			end
			hmwpl_pkg::S_SD_RD2: begin
				if (!(v_q <= min_child)) pos_q <= pick_right ? c1_x[AW-1:0] : c_x[AW-1:0];
			end
			hmwpl_pkg::S_POP_RD0: begin
				if (phase_q == hmwpl_pkg::PH_POPA) x_q <= mem_rdata;
				else y_q <= mem_rdata;
			end
			hmwpl_pkg::S_POP_RDL: begin
				v_q   <= mem_rdata;
				pos_q <= '0;
			end
			hmwpl_pkg::S_MRG_ADD: m_q <= hmwpl_pkg::sat_add(x_q, y_q);
			hmwpl_pkg::S_MRG_PUSH: begin
				sum_q <= hmwpl_pkg::sat_add(sum_q, m_q);
				i_q   <= cnt_q[AW-1:0];
			end
			hmwpl_pkg::S_PU_RD: begin
				if (m_q < mem_rdata) i_q <= parent;
			end
			hmwpl_pkg::S_DONE: begin
				if (out_free) out_data_q <= sum_q;
			end
			default: ;
		endcase
	end

	assign m_tvalid    = out_valid_q;
	assign path_length = out_data_q;

endmodule

### hdl/huffman_min_weighted_path_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_min_weighted_path_length
// Minimum weighted path length of a huffman tree over a set of leaf weights.
// ----------------------------------------------------------------------------
// Usage:
// - slave stream carries one leaf weight per transfer; tlast closes the set.
//   Leaves beyond MAX_LEAVES are dropped, the tlast transfer still closes it.
// - leaves load at one per cycle into the heap memory.
// - after the tlast transfer s_tready drops while a sequencer heapifies the
//   memory and merges the two smallest entries until one is left, summing
//   every merged weight (saturating at 32 bits). One result follows per set.
// - one sift-down level steps through S_SD_CHK, S_SD_RD1 and, with two
//   children, S_SD_RD2, one sift-up level through S_PU_CHK and S_PU_RD, all
//   through the one read and one write port of the heap memory; build sifts
//   down every inner node; a merge pops two entries and pushes their sum.
// - the result sits in an output register; a new set can load while it waits.
//   If a second set finishes before the first result is taken, the block
//   holds s_tready low until m_tready frees the output register.
// - arst_n clears the leaf count and drops m_tvalid; no memory clearing.
// ----------------------------------------------------------------------------
module huffman_min_weighted_path_length #(
	parameter int MAX_LEAVES = hmwpl_pkg::MAX_LEAVES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] leaf_weight
	input  logic        s_tlast,   // last_leaf
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] path_length
);

	localparam int AW = $clog2(MAX_LEAVES);
	localparam int CW = $clog2(MAX_LEAVES + 1);

	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr, mem_raddr;
	logic [hmwpl_pkg::DATA_W-1:0]   mem_wdata, mem_rdata;

	hmwpl_seq #(
		.MAX_LEAVES (MAX_LEAVES),
		.AW         (AW),
		.CW         (CW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.leaf_weight (s_tdata),
		.last_leaf   (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.path_length (m_tdata),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	hmwpl_heap_mem #(
		.DEPTH (MAX_LEAVES),
		.AW    (AW)
	) u_heap_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
